// ===== rtl/gha_pkg.sv =====
`default_nettype none

package gha_pkg;

    // Field widths fixed by the item formats
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int REV_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 5;

    // Default sizes
    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int MAX_STAGES_DEF = 16;

    // Highest revision; a handle at this revision is retired
    localparam logic [REV_W-1:0] REV_MAX = '1;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PEND_FULL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] handle_index;
        logic [REV_W-1:0]   handle_revision;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  out_index;
        logic [REV_W-1:0]    out_revision;
        logic [COUNT_W-1:0]  free_count;
    } t_out;

    // One handle as kept in the ring store
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [REV_W-1:0]   revision;
    } t_handle;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch input item, read ring head
        logic exec;      // apply the item, load the result register
        logic cfg_write; // take the delay register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/generational_handle_allocator_unit.sv =====
// Timing: an item transferred in is captured, then applied into the result register; a result
// still waiting for transfer holds the next item until the output register frees.
// No new item is taken until the last one is applied (capture with ring head read, then apply).
// A tick goes the same way: free list and stages share one ring, a tick moves the boundary.
// Reset (synchronous, active low): free list and stages empty, delay 1; no
// clearing pass, the ring store is read only inside its valid counts.
`default_nettype none

module generational_handle_allocator_unit #(
    parameter int P_MAX_SLOTS  = gha_pkg::MAX_SLOTS_DEF,
    parameter int P_MAX_STAGES = gha_pkg::MAX_STAGES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire gha_pkg::t_in              i_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output gha_pkg::t_out                  o_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [gha_pkg::CFG_W-1:0] i_cfg_data
);

    gha_pkg::t_dp_cmd cmd;

    gha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    gha_datapath #(
        .P_MAX_SLOTS  (P_MAX_SLOTS),
        .P_MAX_STAGES (P_MAX_STAGES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_data),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_data)
    );

    // Busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after a transfer");

    // Config write never lands together with an item
    a_cfg_vs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_valid && o_ready))
        else $error("config write and item transfer in one cycle");

    // No handle granted on a failed step
    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != gha_pkg::ST_OK) |->
            (o_data.out_index == '0 && o_data.out_revision == '0))
        else $error("handle granted with error status");

    // Free list never exceeds the slot count
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_data.free_count) <= P_MAX_SLOTS))
        else $error("free count above slot count");

endmodule

`default_nettype wire

// ===== rtl/gha_ctrl.sv =====
`default_nettype none

module gha_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  wire logic            i_ready,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    output gha_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result register can take a new result this cycle
    assign out_free = !r_out_valid || i_ready;

    // Config writes only between items; config wins over a new item
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_valid     = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd         = '0;
        o_cmd.cfg_write = i_cfg_valid && o_cfg_ready;
        // drop the result once transferred
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the item until the result register is free
                if (out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gha_datapath.sv =====
`default_nettype none

module gha_datapath #(
    parameter int P_MAX_SLOTS  = gha_pkg::MAX_SLOTS_DEF,
    parameter int P_MAX_STAGES = gha_pkg::MAX_STAGES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gha_pkg::t_dp_cmd             i_cmd,
    input  wire gha_pkg::t_in                 i_in_data,
    input  wire logic [gha_pkg::CFG_W-1:0]    i_cfg_data,
    output gha_pkg::t_out                     o_out_data
);

    localparam int AW = (P_MAX_SLOTS > 1) ? $clog2(P_MAX_SLOTS) : 1;
    localparam int CW = $clog2(P_MAX_SLOTS + 1);
    localparam int SW = (P_MAX_STAGES > 1) ? $clog2(P_MAX_STAGES) : 1;
    localparam int DW = $clog2(P_MAX_STAGES + 1);

    localparam logic [AW-1:0] LAST_ADDR = AW'(P_MAX_SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C   = CW'(P_MAX_SLOTS);
    localparam logic [CW:0]   SLOTS_X   = (CW+1)'(P_MAX_SLOTS);
    localparam logic [DW-1:0] STAGES_C  = DW'(P_MAX_STAGES);

    // Ring store: free handles [head, head+free) followed by the pending
    // stages, oldest first, up to tail. A tick only moves the boundary.
    gha_pkg::t_handle r_mem [P_MAX_SLOTS];
    gha_pkg::t_handle r_rd_data;

    gha_pkg::t_in  r_in;
    gha_pkg::t_out r_out, n_out;

    logic [DW-1:0] r_delay, n_delay;
    logic [CW-1:0] r_issued, n_issued;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_free_cnt, n_free_cnt;
    logic [CW-1:0] r_total_cnt, n_total_cnt;
    logic [CW-1:0] r_stage_cnt [P_MAX_STAGES];
    logic [CW-1:0] n_stage_cnt [P_MAX_STAGES];
    logic [SW-1:0] r_oldest, n_oldest;

    logic            mem_we;
    gha_pkg::t_handle mem_wdata;
    logic [SW-1:0]   newest;
    logic [SW-1:0]   oldest_inc;
    logic [SW-1:0]   stage_sel;
    logic [CW-1:0]   stage_val;
    logic [CW:0]     tail_sum;
    logic [CW:0]     tail_wrap;
    logic [DW-1:0]   cfg_delay;

    // Newest stage sits just behind the oldest, wrapping at the delay count
    assign newest     = (r_oldest == '0) ? SW'(r_delay - DW'(1)) : SW'(r_oldest - SW'(1));
    assign oldest_inc = (DW'(r_oldest) + DW'(1) == r_delay) ? '0 : SW'(r_oldest + SW'(1));
    assign stage_sel  = (r_in.mode == gha_pkg::MODE_TICK) ? r_oldest : newest;
    assign stage_val  = r_stage_cnt[stage_sel];

    // Tail after discarding all pending handles
    assign tail_sum  = (CW+1)'(r_head) + (CW+1)'(r_free_cnt);
    assign tail_wrap = (tail_sum >= SLOTS_X) ? tail_sum - SLOTS_X : tail_sum;

    // Clamp the written delay to 1..stages
    always_comb begin
        cfg_delay = DW'(i_cfg_data);
        if (i_cfg_data == '0) begin
            cfg_delay = DW'(1);
        end else if (int'(i_cfg_data) > P_MAX_STAGES) begin
            cfg_delay = STAGES_C;
        end
    end

    // Apply one item, or a config write
    always_comb begin
        n_delay     = r_delay;
        n_issued    = r_issued;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free_cnt  = r_free_cnt;
        n_total_cnt = r_total_cnt;
        n_stage_cnt = r_stage_cnt;
        n_oldest    = r_oldest;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = '0;

        if (i_cmd.cfg_write) begin
            n_delay     = cfg_delay;
            n_oldest    = '0;
            n_total_cnt = r_free_cnt;
            n_tail      = AW'(tail_wrap);
            for (int s = 0; s < P_MAX_STAGES; s++) begin
                n_stage_cnt[s] = '0;
            end
        end else if (i_cmd.exec) begin
            n_out.status       = gha_pkg::ST_OK;
            n_out.out_index    = '0;
            n_out.out_revision = '0;
            case (r_in.mode)
                gha_pkg::MODE_ALLOC: begin
                    if (r_free_cnt != '0) begin
                        n_out.out_index    = r_rd_data.index;
                        n_out.out_revision = r_rd_data.revision;
                        n_head      = (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
                        n_free_cnt  = r_free_cnt - CW'(1);
                        n_total_cnt = r_total_cnt - CW'(1);
                    end else if (r_issued < SLOTS_C) begin
                        n_out.out_index = gha_pkg::INDEX_W'(r_issued);
                        n_issued        = r_issued + CW'(1);
                    end else begin
                        n_out.status = gha_pkg::ST_NO_SLOT;
                    end
                end
                gha_pkg::MODE_RELEASE: begin
                    if (r_in.handle_revision == gha_pkg::REV_MAX) begin
                        n_out.status = gha_pkg::ST_DROPPED;
                    end else if (r_total_cnt >= SLOTS_C) begin
                        n_out.status = gha_pkg::ST_PEND_FULL;
                    end else begin
                        mem_we             = 1'b1;
                        mem_wdata.index    = r_in.handle_index;
                        mem_wdata.revision = r_in.handle_revision + gha_pkg::REV_W'(1);
                        n_tail      = (r_tail == LAST_ADDR) ? '0 : r_tail + AW'(1);
                        n_total_cnt = r_total_cnt + CW'(1);
                        n_stage_cnt[stage_sel] = stage_val + CW'(1);
                    end
                end
                gha_pkg::MODE_TICK: begin
                    // oldest stage joins the free list in place
                    n_free_cnt             = r_free_cnt + stage_val;
                    n_stage_cnt[stage_sel] = '0;
                    n_oldest               = oldest_inc;
                end
                default: begin
                end
            endcase
            n_out.free_count = gha_pkg::COUNT_W'(n_free_cnt);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= DW'(1);
            r_issued    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_free_cnt  <= '0;
            r_total_cnt <= '0;
            r_oldest    <= '0;
            for (int s = 0; s < P_MAX_STAGES; s++) begin
                r_stage_cnt[s] <= '0;
            end
        end else begin
            r_delay     <= n_delay;
            r_issued    <= n_issued;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free_cnt  <= n_free_cnt;
            r_total_cnt <= n_total_cnt;
            r_oldest    <= n_oldest;
            r_stage_cnt <= n_stage_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        r_out <= n_out;
    end

    // Ring store: read the head on capture, write the tail on release
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[r_head];
        end
        if (mem_we) begin
            r_mem[r_tail] <= mem_wdata;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire
